// File: rtl/deterministic_primality_test_assert.svh
// Assertion macros for the primality test RTL
`ifndef DETERMINISTIC_PRIMALITY_TEST_ASSERT_SVH
`define DETERMINISTIC_PRIMALITY_TEST_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define DPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/dpt_pkg.sv
// ---------------------------------------------------------------------------
// dpt_pkg
// Constants and types shared by the primality test modules.
// ---------------------------------------------------------------------------
package dpt_pkg;
  localparam int VALUE_BITS_DEF = 63;
  localparam logic [31:0] SMALL_PRIME_MASK = 32'h208A28AC;
  localparam int NUM_TRIAL = 25;
  localparam int NUM_WIT_TOTAL = 17;

  // trial divisor table, all below 128
  function automatic logic [6:0] trial_prime(input logic [4:0] idx);
    logic [6:0] p;
    case (idx)
      5'd0: p = 7'd2;    5'd1: p = 7'd3;    5'd2: p = 7'd5;    5'd3: p = 7'd7;
      5'd4: p = 7'd11;   5'd5: p = 7'd13;   5'd6: p = 7'd17;   5'd7: p = 7'd19;
      5'd8: p = 7'd23;   5'd9: p = 7'd29;   5'd10: p = 7'd31;  5'd11: p = 7'd37;
      5'd12: p = 7'd41;  5'd13: p = 7'd43;  5'd14: p = 7'd47;  5'd15: p = 7'd53;
      5'd16: p = 7'd59;  5'd17: p = 7'd61;  5'd18: p = 7'd67;  5'd19: p = 7'd71;
      5'd20: p = 7'd73;  5'd21: p = 7'd79;  5'd22: p = 7'd83;  5'd23: p = 7'd89;
      5'd24: p = 7'd97;
      default: p = 7'd2;
    endcase
    return p;
  endfunction

  // witness table, all sets laid out back to back
  function automatic logic [31:0] witness(input logic [4:0] idx);
    logic [31:0] w;
    case (idx)
      5'd0: w = 32'd377687;
      5'd1: w = 32'd31;      5'd2: w = 32'd73;
      5'd3: w = 32'd2;       5'd4: w = 32'd7;     5'd5: w = 32'd61;
      5'd6: w = 32'd2;       5'd7: w = 32'd13;    5'd8: w = 32'd23;
      5'd9: w = 32'd1662803;
      5'd10: w = 32'd2;      5'd11: w = 32'd325;  5'd12: w = 32'd9375;
      5'd13: w = 32'd28178;  5'd14: w = 32'd450775;
      5'd15: w = 32'd9780504; 5'd16: w = 32'd1795265022;
      default: w = 32'd2;
    endcase
    return w;
  endfunction

  // modular multiply request / status between control and multiplier
  typedef struct packed {
    logic start;
  } mm_ctl_t;
  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;
endpackage

// File: rtl/dpt_if.sv
// ---------------------------------------------------------------------------
// dpt_if
// Valid/ready channel carrying one payload word.
// ---------------------------------------------------------------------------
interface dpt_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dpt_rem.sv
// ---------------------------------------------------------------------------
// dpt_rem
// Bit-serial remainder: one restoring step per cycle, MSB first.
// ---------------------------------------------------------------------------
module dpt_rem import dpt_pkg::*; #(
  parameter int VB = VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VB-1:0] num,
  input  logic [VB-1:0] den,
  output logic          done,
  output logic [VB-1:0] rem
);
  localparam int CW = $clog2(VB + 1);
  logic [VB-1:0] num_r, rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [VB:0]   sh;

  // shift in next numerator bit and trial subtract
  assign sh = {rem_r, num_r[VB-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CW'(VB);
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (sh >= {1'b0, den_r}) rem_r <= VB'(sh - {1'b0, den_r});
        else rem_r <= VB'(sh);
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign done = done_r;
  assign rem  = rem_r;
endmodule

// File: rtl/dpt_mulmod.sv
// ---------------------------------------------------------------------------
// dpt_mulmod
// Shift-add modular multiply, one multiplier bit per cycle, LSB first.
// ---------------------------------------------------------------------------
module dpt_mulmod import dpt_pkg::*; #(
  parameter int VB = VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mm_ctl_t       ctl,
  input  logic [VB-1:0] x,
  input  logic [VB-1:0] y,
  input  logic [VB-1:0] m,
  output mm_sts_t       sts,
  output logic [VB-1:0] p
);
  logic [VB-1:0] x_r, y_r, acc_r;
  logic          busy_r, done_r;
  logic [VB:0]   sa, sd;
  logic [VB-1:0] acc_nxt, x_nxt;

  // conditional add and double, both reduced by one subtract
  always_comb begin
    sa = {1'b0, acc_r} + {1'b0, x_r};
    sd = {1'b0, x_r} + {1'b0, x_r};
    acc_nxt = acc_r;
    if (y_r[0]) acc_nxt = (sa >= {1'b0, m}) ? VB'(sa - {1'b0, m}) : VB'(sa);
    x_nxt = (sd >= {1'b0, m}) ? VB'(sd - {1'b0, m}) : VB'(sd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        x_r    <= x;
        y_r    <= y;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (y_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          acc_r <= acc_nxt;
          x_r   <= x_nxt;
          y_r   <= y_r >> 1;
        end
      end
    end
  end
  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign p = acc_r;
endmodule

// File: rtl/deterministic_primality_test.sv
// Sequence: candidates below 31 are answered from a bitmask; larger ones take one
//   bit-serial reduction per trial divisor, then per witness one reduction plus up to
//   about 2*VALUE_BITS modular multiplies.
// Throughput: one request at a time; the next is accepted after the result leaves.
// Reset: synchronous active-low rst_n returns the sequencer to idle, no result pending.
// ---------------------------------------------------------------------------
// deterministic_primality_test
// Deterministic Miller-Rabin primality test over a bit-serial datapath.
// ---------------------------------------------------------------------------
`include "deterministic_primality_test_assert.svh"
module deterministic_primality_test import dpt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  dpt_if.sink   in_ch,
  dpt_if.source out_ch
);
  localparam int VB = VALUE_BITS;
  localparam int SW = $clog2(VB + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SMALL, S_TRIAL, S_TRIAL_W, S_SEL, S_STRIP,
    S_WRED, S_WRED_W, S_EXP, S_EXP_MA, S_EXP_MA_W, S_EXP_SQ, S_EXP_SQ_W,
    S_CHK, S_SQR, S_SQR_W, S_OUT
  } state_t;

  state_t        state_r;
  logic [VB-1:0] n_r, odd_r, e_r, b_r, acc_r, nm1_r;
  logic [SW-1:0] s_r, r_r;
  logic [4:0]    ti_r, wi_r, wend_r;
  logic          res_r, oval_r;

  logic          rem_start;
  logic [VB-1:0] rem_num, rem_den, rem_q;
  logic          rem_done;
  mm_ctl_t       mm_ctl;
  mm_sts_t       mm_sts;
  logic [VB-1:0] mm_x, mm_y, mm_p;

  dpt_rem #(.VB(VB)) u_rem (
    .clk, .rst_n, .start(rem_start), .num(rem_num), .den(rem_den),
    .done(rem_done), .rem(rem_q)
  );
  dpt_mulmod #(.VB(VB)) u_mm (
    .clk, .rst_n, .ctl(mm_ctl), .x(mm_x), .y(mm_y), .m(n_r),
    .sts(mm_sts), .p(mm_p)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = oval_r;
  assign out_ch.data  = res_r;

  // unit start strobes and operands
  always_comb begin
    rem_start = (state_r == S_TRIAL) || (state_r == S_WRED);
    rem_num   = n_r;
    rem_den   = VB'(trial_prime(ti_r));
    if (state_r == S_WRED) begin
      rem_num = VB'(witness(wi_r));
      rem_den = n_r;
    end
    mm_ctl.start = (state_r == S_EXP_MA) || (state_r == S_EXP_SQ) || (state_r == S_SQR);
    mm_x = b_r;
    mm_y = b_r;
    if (state_r == S_EXP_MA) mm_x = acc_r;
    if (state_r == S_SQR) begin
      mm_x = acc_r;
      mm_y = acc_r;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          n_r     <= in_ch.data[VB-1:0];
          state_r <= S_SMALL;
        end
        S_SMALL: begin
          ti_r  <= '0;
          nm1_r <= n_r - 1'b1;
          if (n_r < VB'(31)) begin
            res_r   <= SMALL_PRIME_MASK[n_r[4:0]];
            state_r <= S_OUT;
          end else state_r <= S_TRIAL;
        end
        S_TRIAL: state_r <= S_TRIAL_W;
        S_TRIAL_W: if (rem_done) begin
          if (rem_q == '0) begin
            res_r   <= 1'b0;
            state_r <= S_OUT;
          end else if (ti_r == 5'd6 && n_r < VB'(323)) begin
            res_r   <= 1'b1;
            state_r <= S_OUT;
          end else if (ti_r == 5'(NUM_TRIAL - 1)) state_r <= S_SEL;
          else begin
            ti_r    <= ti_r + 1'b1;
            state_r <= S_TRIAL;
          end
        end
        S_SEL: begin
          odd_r <= nm1_r;
          s_r   <= '0;
          res_r <= 1'b1;
          if (n_r < VB'(5329)) begin wi_r <= 5'd0; wend_r <= 5'd1; end
          else if (n_r < VB'(9080191)) begin wi_r <= 5'd1; wend_r <= 5'd3; end
          else if (64'(n_r) < 64'd4759123141) begin wi_r <= 5'd3; wend_r <= 5'd6; end
          else if (64'(n_r) < 64'd1122004669633) begin wi_r <= 5'd6; wend_r <= 5'd10; end
          else begin wi_r <= 5'd10; wend_r <= 5'(NUM_WIT_TOTAL); end
          state_r <= S_STRIP;
        end
        S_STRIP: begin
          if (odd_r[0]) state_r <= S_WRED;
          else begin
            odd_r <= odd_r >> 1;
            s_r   <= s_r + 1'b1;
          end
        end
        S_WRED: state_r <= S_WRED_W;
        S_WRED_W: if (rem_done) begin
          if (rem_q == '0) state_r <= S_CHK;
          else begin
            b_r     <= rem_q;
            e_r     <= odd_r;
            acc_r   <= VB'(1);
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (e_r == '0) begin
            r_r <= SW'(1);
            if (acc_r == VB'(1) || acc_r == nm1_r) state_r <= S_CHK;
            else if (s_r <= SW'(1)) begin
              res_r <= 1'b0;
              state_r <= S_OUT;
            end else state_r <= S_SQR;
          end else if (!mm_sts.busy && !mm_sts.done) begin
            state_r <= e_r[0] ? S_EXP_MA : S_EXP_SQ;
          end
        end
        // exponent bit set: acc = acc * b
        S_EXP_MA: state_r <= S_EXP_MA_W;
        S_EXP_MA_W: if (mm_sts.done) begin
          acc_r   <= mm_p;
          state_r <= S_EXP_SQ;
        end
        // base squaring, then next exponent bit
        S_EXP_SQ: state_r <= S_EXP_SQ_W;
        S_EXP_SQ_W: if (mm_sts.done) begin
          b_r     <= mm_p;
          e_r     <= e_r >> 1;
          state_r <= S_EXP;
        end
        S_SQR: state_r <= S_SQR_W;
        S_SQR_W: if (mm_sts.done) begin
          acc_r <= mm_p;
          if (mm_p == VB'(1)) begin
            res_r <= 1'b0;
            state_r <= S_OUT;
          end else if (mm_p == nm1_r) state_r <= S_CHK;
          else if (r_r + 1'b1 >= s_r) begin
            res_r <= 1'b0;
            state_r <= S_OUT;
          end else begin
            r_r <= r_r + 1'b1;
            state_r <= S_SQR;
          end
        end
        S_CHK: begin
          if (wi_r + 1'b1 == wend_r) state_r <= S_OUT;
          else begin
            wi_r    <= wi_r + 1'b1;
            state_r <= S_WRED;
          end
        end
        S_OUT: begin
          oval_r <= 1'b1;
          if (oval_r && out_ch.ready) begin
            oval_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DPT_ASSERT_IMP(a_out_only_in_out, clk, rst_n, oval_r, state_r == S_OUT)
  `DPT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `DPT_ASSERT_NXT(a_done_pulse, clk, rst_n, mm_sts.done, !mm_sts.done)
endmodule

// File: tb/sv/deterministic_primality_test_test.sv
// ---------------------------------------------------------------------------
// deterministic_primality_test_test
// Self-checking bench for the primality tester. A directed table covers the
// small-value bitmask, trial division limits, witness set boundaries and
// strong pseudoprimes. Random candidates of mixed magnitude follow. Every
// result is checked against the typed-in verdict or a local Miller-Rabin
// predictor, with random idling on both channels and a long receiver hold.
// ---------------------------------------------------------------------------
module deterministic_primality_test_test import dpt_pkg::*;;

  localparam int VB = VALUE_BITS_DEF;
  // expectation column: 0/1 typed in, or take the predictor's answer
  localparam logic [1:0] EXP_NO = 2'd0;
  localparam logic [1:0] EXP_YES = 2'd1;
  localparam logic [1:0] EXP_CALC = 2'd2;

  typedef struct {
    logic [VB-1:0] value;
    logic [1:0]    verdict;
  } probe_t;

  logic clk;
  logic rst_n;
  dpt_if #(.W(VB)) in_ch ();
  dpt_if #(.W(1))  out_ch ();

  deterministic_primality_test u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic verdict_q[$];
  int   err_cnt = 0;
  int   tx_idle = 25;
  int   rx_idle = 61;
  int   rx_hold;

  // directed candidates
  probe_t probes[] = '{
    '{63'd0, EXP_NO}, '{63'd1, EXP_NO}, '{63'd2, EXP_YES}, '{63'd3, EXP_YES},
    '{63'd4, EXP_NO}, '{63'd29, EXP_YES}, '{63'd30, EXP_NO}, '{63'd31, EXP_YES},
    '{63'd97, EXP_YES}, '{63'd289, EXP_NO}, '{63'd307, EXP_CALC}, '{63'd323, EXP_NO},
    '{63'd5329, EXP_NO}, '{63'd5333, EXP_CALC}, '{63'd9080191, EXP_NO},
    '{63'd3215031751, EXP_NO}, '{63'd4759123141, EXP_NO},
    '{63'd1122004669633, EXP_CALC}, '{63'h1FFF_FFFF_FFFF_FFFF, EXP_YES},
    '{63'd9223372036854775783, EXP_CALC}, '{63'h7FFF_FFFF_FFFF_FFFF, EXP_CALC}
  };

  // modular helpers, all operands below 2^63 so 64-bit sums cannot wrap
  function automatic longint unsigned mod_add(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    longint unsigned s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 0;
    a = a % m;
    b = b % m;
    while (b != 0) begin
      if (b[0]) acc = mod_add(acc, a, m);
      a = mod_add(a, a, m);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic strong_probable(longint unsigned a, longint unsigned n,
                                           longint unsigned d, int s);
    longint unsigned x;
    if (a % n == 0) return 1'b1;
    x = mod_pow(a, d, n);
    if (x == 1 || x == n - 1) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = mod_mul(x, x, n);
      if (x == 1) return 1'b0;
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic primality(logic [VB-1:0] cand);
    longint unsigned n, d;
    longint unsigned bases[$];
    longint unsigned divs[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                  43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    int s;
    n = 64'(cand);
    if (n < 31) return (n == 2 || n == 3 || n == 5 || n == 7 || n == 11 || n == 13 ||
                        n == 17 || n == 19 || n == 23 || n == 29);
    for (int i = 0; i < 7; i++) if (n % divs[i] == 0) return 1'b0;
    if (n < 323) return 1'b1;
    for (int i = 7; i < 25; i++) if (n % divs[i] == 0) return 1'b0;
    if (n < 5329) bases = '{377687};
    else if (n < 9080191) bases = '{31, 73};
    else if (n < 64'd4759123141) bases = '{2, 7, 61};
    else if (n < 64'd1122004669633) bases = '{2, 13, 23, 1662803};
    else bases = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    foreach (bases[i]) if (!strong_probable(bases[i], n, d, s)) return 1'b0;
    return 1'b1;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offer one candidate; valid is lowered only when an idle gap is taken
  task automatic offer(logic [VB-1:0] cand, logic [1:0] verdict);
    logic want;
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= cand;
    do @(posedge clk); while (!in_ch.ready);
    want = primality(cand);
    if (verdict != EXP_CALC && want !== verdict[0]) begin
      $display("%0t: predictor disagrees on %0d: table %0d predictor %0d",
               $time, cand, verdict[0], want);
      err_cnt++;
    end
    verdict_q.push_back(verdict == EXP_CALC ? want : verdict[0]);
  endtask

  // mostly small magnitudes, a few full width
  function automatic logic [VB-1:0] pick_candidate();
    int sel;
    logic [VB-1:0] v;
    sel = $urandom_range(99);
    v = VB'({$urandom, $urandom});
    if (sel < 55) v = v & 63'hF_FFFF;
    else if (sel < 85) v = v & 63'hFFFF_FFFF;
    else if (sel < 92) v = v & 63'hFF_FFFF_FFFF;
    if ($urandom_range(1)) v[0] = 1'b1;
    return v;
  endfunction

  // receiver ready, with a counted hold-off right after reset
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 400;
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %0d", $time, out_ch.data);
        err_cnt++;
      end else begin
        if (out_ch.data[0] !== verdict_q[0]) begin
          $display("%0t: is_prime mismatch: expected %0d actual %0d",
                   $time, verdict_q[0], out_ch.data[0]);
          err_cnt++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (probes[i]) offer(probes[i].value, probes[i].verdict);
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
      rx_idle = (phase == 0) ? 61 : (phase == 1) ? 25 : 0;
      for (int k = 0; k < 27; k++) offer(pick_candidate(), EXP_CALC);
    end
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("deterministic_primality_test_test: PASS");
    end else begin
      $display("deterministic_primality_test_test: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000000;
    $display("deterministic_primality_test_test: FAIL");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/dpt_pkg.sv
rtl/dpt_if.sv
rtl/dpt_rem.sv
rtl/dpt_mulmod.sv
rtl/deterministic_primality_test.sv
tb/sv/deterministic_primality_test_test.sv
